>>> hw/rtl/mvsg_pkg.sv
// Package for the motion vector segment generator: constants, payload and pipeline types.
`default_nettype none
package mvsg_pkg;

  // Block dimensions.
  localparam int MESH_DIM   = 8;
  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 48;
  localparam int TEX_WIDTH  = 512;
  localparam int TEX_HEIGHT = 256;

  // Mesh storage geometry: six vertices per cell, stored as two rows of three lanes.
  localparam int MESH_CELLS = MESH_DIM * MESH_DIM;
  localparam int MESH_SLOTS = MESH_CELLS * 6;
  localparam int MESH_ROWS  = MESH_CELLS * 2;
  localparam int ROW_W      = $clog2(MESH_ROWS);
  localparam int CB         = $clog2(MESH_DIM);
  localparam int AX_W       = 16 + CB;

  // Slot to cell conversion: slot / 6 as a multiply by a reciprocal, exact for slots below 2048.
  localparam int SLOT_RECIP = 683;
  localparam int SLOT_SHIFT = 12;

  // Kept window for point positions, Q16.
  localparam int EDGE_LO = 7;
  localparam int EDGE_HI = 65529;

  // Datapath widths.
  localparam int PX_W    = 19;
  localparam int X_W     = 34;
  localparam int MAG_W   = 33;
  localparam int COORD_W = $clog2((TEX_WIDTH > TEX_HEIGHT) ? TEX_WIDTH : TEX_HEIGHT) + 17;
  localparam int DEN_W   = MAG_W + 4;
  localparam int PR_W    = COORD_W + MAG_W;
  localparam int DV_W    = PR_W + 1;
  localparam int PD_BITS = 17;
  localparam int SQ_BITS = 12;
  localparam int ND_BITS = 13;
  localparam int CQ_BITS = COORD_W - 4;
  localparam int QW      = CQ_BITS;
  localparam int TEX_W_Q = TEX_WIDTH * 65536;
  localparam int TEX_H_Q = TEX_HEIGHT * 65536;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE       = 3'd0;
  localparam logic [2:0] REG_COLOR_RGBA   = 3'd1;
  localparam logic [2:0] REG_DENSITY_COLS = 3'd2;
  localparam logic [2:0] REG_DENSITY_ROWS = 3'd3;
  localparam logic [2:0] REG_OFFSET_X     = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd5;
  localparam logic [2:0] REG_VECTOR_SCALE = 3'd6;

  // Input item.
  typedef struct packed {
    logic               func;
    logic [8:0]         mesh_slot;
    logic signed [15:0] mesh_u;
    logic signed [15:0] mesh_v;
    logic [5:0]         grid_col;
    logic [5:0]         grid_row;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [13:0] start_x;
    logic [12:0] start_y;
    logic [13:0] end_x;
    logic [12:0] end_y;
    logic [31:0] seg_color;
  } out_item_t;

  // One pipeline stage's contents.
  typedef struct packed {
    logic                     vld;
    logic                     ld;
    logic                     wen;
    logic                     ok;
    logic                     nrm;
    logic                     zero;
    logic                     xt;
    logic                     yt;
    logic                     sgnx;
    logic                     sgny;
    logic [ROW_W-1:0]         row;
    logic [1:0]               lane;
    logic [31:0]              wdata;
    logic [DV_W-1:0]          rem_a;
    logic [DV_W-1:0]          rem_b;
    logic [DEN_W-1:0]         den_a;
    logic [DEN_W-1:0]         den_b;
    logic [QW-1:0]            quo_a;
    logic [QW-1:0]            quo_b;
    logic signed [PX_W-1:0]   px;
    logic signed [PX_W-1:0]   py;
    logic [16:0]              w0;
    logic [16:0]              w1;
    logic [16:0]              w2;
    logic signed [32:0]       pu0;
    logic signed [32:0]       pu1;
    logic signed [32:0]       pu2;
    logic signed [32:0]       pv0;
    logic signed [32:0]       pv1;
    logic signed [32:0]       pv2;
    logic signed [X_W-1:0]    xu;
    logic signed [X_W-1:0]    xv;
    logic signed [X_W-1:0]    dx;
    logic signed [X_W-1:0]    dy;
    logic [COORD_W-1:0]       sx;
    logic [COORD_W-1:0]       sy;
    logic [COORD_W-1:0]       room_x;
    logic [COORD_W-1:0]       room_y;
    logic [COORD_W-1:0]       tn;
    logic [MAG_W-1:0]         ax;
    logic [MAG_W-1:0]         ay;
    logic [PR_W-1:0]          pyx;
    logic [PR_W-1:0]          pxy;
    logic [13:0]              ex;
    logic [12:0]              ey;
  } stage_t;

endpackage
`default_nettype wire

>>> hw/rtl/motion_vector_segment_gen.sv
// Top level of the motion vector segment generator: one pipeline around the mesh memory.
//
// Input channel (in_valid, in_ready, in_data): a load item (func zero) writes one mesh
// vertex; a grid-point item (func one) yields at most one segment on the result channel
// (out_valid, out_ready, out_data). Configuration is a plain write port (cfg_we,
// cfg_index, cfg_wdata), which the user must write only while the block is idle;
// the block does not enforce this. Throughput is one item per cycle while not stalled.
// The pipeline holds the bit-serial stages of the position divider (17), the square root
// (12), the normalizing divider (13) and the clip divider (22).
// Load items write the mesh memory at the same pipeline stage where points read it, so
// every point sees exactly the loads that were transferred before it.
// Items that give no segment simply leave the pipeline.
// Reset clears the pipeline and the output register and restores the register defaults;
// the mesh memory is not cleared and must be loaded before points use it.
// When the receiver stalls, the output register holds its segment and the pipeline keeps
// moving until a finished segment reaches its last stage; only then does in_ready drop.
`default_nettype none
module motion_vector_segment_gen import mvsg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  // Stage map of the pipeline.
  localparam int K_PD0  = 0;
  localparam int K_POS  = K_PD0 + PD_BITS;
  localparam int K_ADDR = K_POS + 1;
  localparam int K_MUL  = K_ADDR + 1;
  localparam int K_SUM  = K_MUL + 1;
  localparam int K_SCL  = K_SUM + 1;
  localparam int K_LEN  = K_SCL + 1;
  localparam int K_SQ0  = K_LEN + 1;
  localparam int K_NUM  = K_SQ0 + SQ_BITS;
  localparam int K_ND0  = K_NUM + 1;
  localparam int K_FIN  = K_ND0 + ND_BITS;
  localparam int K_C1   = K_FIN + 1;
  localparam int K_C2   = K_C1 + 1;
  localparam int K_C3   = K_C2 + 1;
  localparam int K_C4   = K_C3 + 1;
  localparam int K_CD0  = K_C4 + 1;
  localparam int K_END  = K_CD0 + CQ_BITS;
  localparam int NST    = K_END + 1;

  // Configuration registers.
  logic               enable_r;
  logic [31:0]        color_r;
  logic [15:0]        dens_c_r;
  logic [15:0]        dens_r_r;
  logic signed [17:0] ofs_x_r;
  logic signed [17:0] ofs_y_r;
  logic signed [15:0] scale_r;

  // Pipeline, mesh memory and output register.
  stage_t            pipe [0:NST];
  stage_t            ent;
  stage_t            addr_st;
  logic [3*32-1:0]   mesh_mem [0:MESH_ROWS-1];
  logic [3*32-1:0]   rd_r;
  logic              out_valid_r;
  out_item_t         out_data_r;
  logic              stall;
  logic              adv;
  logic              last_res;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      color_r  <= 32'd0;
      dens_c_r <= 16'd8192;
      dens_r_r <= 16'd6144;
      ofs_x_r  <= 18'sd0;
      ofs_y_r  <= 18'sd0;
      scale_r  <= 16'sd256;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE:       enable_r <= cfg_wdata[0];
        REG_COLOR_RGBA:   color_r  <= cfg_wdata;
        REG_DENSITY_COLS: dens_c_r <= cfg_wdata[15:0];
        REG_DENSITY_ROWS: dens_r_r <= cfg_wdata[15:0];
        REG_OFFSET_X:     ofs_x_r  <= $signed(cfg_wdata[17:0]);
        REG_OFFSET_Y:     ofs_y_r  <= $signed(cfg_wdata[17:0]);
        REG_VECTOR_SCALE: scale_r  <= $signed(cfg_wdata[15:0]);
        default: ;
      endcase
    end
  end

  // Magnitude of a signed vector component.
  function automatic logic [MAG_W-1:0] mag_of(input logic signed [X_W-1:0] v);
    logic signed [X_W-1:0] n;
    n = -v;
    return v[X_W-1] ? MAG_W'(n) : MAG_W'(v);
  endfunction

  // Work of one pipeline stage on the item it holds.
  function automatic stage_t step_fn(input int k, input stage_t it, input logic [3*32-1:0] rd);
    stage_t                  o;
    int                      b;
    logic [DV_W-1:0]         sh_a;
    logic [DV_W-1:0]         sh_b;
    logic [AX_W-1:0]         axp;
    logic [AX_W-1:0]         ayp;
    logic [CB-1:0]           cx;
    logic [CB-1:0]           cy;
    logic [15:0]             fx;
    logic [15:0]             fy;
    logic [16:0]             fsum;
    logic                    tri_sel;
    logic signed [X_W-1:0]   acc_u;
    logic signed [X_W-1:0]   acc_v;
    logic signed [X_W+15:0]  prod_u;
    logic signed [X_W+15:0]  prod_v;
    logic signed [25:0]      ex13;
    logic signed [25:0]      ey13;
    logic [25:0]             sqx;
    logic [25:0]             sqy;
    logic [24:0]             len2;
    logic                    short_vec;
    logic [MAG_W-1:0]        mx;
    logic [MAG_W-1:0]        my;
    logic                    ysel;
    logic signed [COORD_W+1:0] e;
    logic signed [COORD_W+1:0] q16;
    o = it;
    b = 0;
    if (k < K_POS) begin
      // Position divider, one quotient bit per stage.
      b = PD_BITS - 1 - (k - K_PD0);
      sh_a = DV_W'(it.den_a) << b;
      sh_b = DV_W'(it.den_b) << b;
      if (it.rem_a >= sh_a) begin
        o.rem_a = it.rem_a - sh_a;
        o.quo_a[b] = 1'b1;
      end
      if (it.rem_b >= sh_b) begin
        o.rem_b = it.rem_b - sh_b;
        o.quo_b[b] = 1'b1;
      end
    end else if (k == K_POS) begin
      // Add the x offset, subtract the y offset, and drop points near the edges.
      o.px = $signed({2'b00, it.quo_a[PD_BITS-1:0]}) + PX_W'(ofs_x_r);
      o.py = $signed({2'b00, it.quo_b[PD_BITS-1:0]}) - PX_W'(ofs_y_r);
      o.ok = it.ok && (o.px >= EDGE_LO) && (o.px <= EDGE_HI) &&
             (o.py >= EDGE_LO) && (o.py <= EDGE_HI);
    end else if (k == K_ADDR) begin
      // Locate the cell and triangle and form the barycentric weights.
      axp  = AX_W'(AX_W'(it.px[15:0]) * MESH_DIM);
      ayp  = AX_W'(AX_W'(it.py[15:0]) * MESH_DIM);
      cx   = axp[AX_W-1:16];
      cy   = ayp[AX_W-1:16];
      fx   = axp[15:0];
      fy   = ayp[15:0];
      fsum = {1'b0, fx} + {1'b0, fy};
      tri_sel = fsum > 17'd65536;
      if (tri_sel) begin
        o.w0 = 17'd65536 - {1'b0, fy};
        o.w1 = fsum - 17'd65536;
        o.w2 = 17'd65536 - {1'b0, fx};
      end else begin
        o.w0 = 17'd65536 - fsum;
        o.w1 = {1'b0, fx};
        o.w2 = {1'b0, fy};
      end
      if (!it.ld) begin
        o.row = ROW_W'((ROW_W'(cy) * MESH_DIM + ROW_W'(cx)) * 2 + ROW_W'(tri_sel));
      end
    end else if (k == K_MUL) begin
      // Weight the three vertices.
      o.pu0 = 33'($signed(rd[15:0]))  * 33'($signed({1'b0, it.w0}));
      o.pu1 = 33'($signed(rd[47:32])) * 33'($signed({1'b0, it.w1}));
      o.pu2 = 33'($signed(rd[79:64])) * 33'($signed({1'b0, it.w2}));
      o.pv0 = 33'($signed(rd[31:16])) * 33'($signed({1'b0, it.w0}));
      o.pv1 = 33'($signed(rd[63:48])) * 33'($signed({1'b0, it.w1}));
      o.pv2 = 33'($signed(rd[95:80])) * 33'($signed({1'b0, it.w2}));
    end else if (k == K_SUM) begin
      // Interpolated UV minus half a texel minus the position, Q20 texels.
      acc_u = X_W'(it.pu0) + X_W'(it.pu1) + X_W'(it.pu2);
      acc_v = X_W'(it.pv0) + X_W'(it.pv1) + X_W'(it.pv2);
      o.xu = acc_u - X_W'(2 ** 19) - X_W'(it.px) * X_W'(TEX_WIDTH * 16);
      o.xv = acc_v - X_W'(2 ** 19) - X_W'(it.py) * X_W'(TEX_HEIGHT * 16);
    end else if (k == K_SCL) begin
      // Scale into a Q12 motion vector, rounding toward minus infinity.
      prod_u = (X_W+16)'(it.xu) * (X_W+16)'(scale_r);
      prod_v = (X_W+16)'(it.xv) * (X_W+16)'(scale_r);
      o.dx = X_W'(prod_u >>> 16);
      o.dy = X_W'(prod_v >>> 16);
    end else if (k == K_LEN) begin
      // Squared length, needed only when both components are short.
      short_vec = (it.dx >= -4095) && (it.dx <= 4095) && (it.dy >= -4095) &&
                  (it.dy <= 4095);
      ex13 = 26'($signed(it.dx[12:0]));
      ey13 = 26'($signed(it.dy[12:0]));
      sqx  = 26'(ex13 * ex13);
      sqy  = 26'(ey13 * ey13);
      len2 = 25'(sqx) + 25'(sqy);
      o.zero  = (it.dx == 0) && (it.dy == 0);
      o.nrm   = short_vec && !o.zero && (len2 < 25'(2 ** 24));
      o.rem_a = DV_W'(len2);
      o.quo_a = '0;
    end else if (k < K_NUM) begin
      // Square root, one result bit per stage; the remainder is len2 - root^2.
      b = SQ_BITS - 1 - (k - K_SQ0);
      sh_a = (DV_W'(it.quo_a) << (b + 1)) + (DV_W'(1) << (2 * b));
      if (it.rem_a >= sh_a) begin
        o.rem_a = it.rem_a - sh_a;
        o.quo_a[b] = 1'b1;
      end
    end else if (k == K_NUM) begin
      // Set up the normalizing division by the length.
      mx = mag_of(it.dx);
      my = mag_of(it.dy);
      o.den_a = DEN_W'(it.quo_a[SQ_BITS-1:0]);
      o.den_b = DEN_W'(it.quo_a[SQ_BITS-1:0]);
      o.rem_a = DV_W'(mx[11:0]) << 12;
      o.rem_b = DV_W'(my[11:0]) << 12;
      o.quo_a = '0;
      o.quo_b = '0;
    end else if (k < K_FIN) begin
      // Normalizing divider, one quotient bit per stage.
      b = ND_BITS - 1 - (k - K_ND0);
      sh_a = DV_W'(it.den_a) << b;
      sh_b = DV_W'(it.den_b) << b;
      if (it.rem_a >= sh_a) begin
        o.rem_a = it.rem_a - sh_a;
        o.quo_a[b] = 1'b1;
      end
      if (it.rem_b >= sh_b) begin
        o.rem_b = it.rem_b - sh_b;
        o.quo_b[b] = 1'b1;
      end
    end else if (k == K_FIN) begin
      // Zero vectors become (1,1); short vectors become unit length.
      if (it.zero) begin
        o.dx = X_W'(4096);
        o.dy = X_W'(4096);
      end else if (it.nrm) begin
        o.dx = it.dx[X_W-1] ? -X_W'(it.quo_a[ND_BITS-1:0]) : X_W'(it.quo_a[ND_BITS-1:0]);
        o.dy = it.dy[X_W-1] ? -X_W'(it.quo_b[ND_BITS-1:0]) : X_W'(it.quo_b[ND_BITS-1:0]);
      end
    end else if (k == K_C1) begin
      // Start points, room to the texture border, and per-axis clip tests.
      o.sx = COORD_W'(COORD_W'(it.px[15:0]) * TEX_WIDTH);
      o.sy = COORD_W'(COORD_W'(it.py[15:0]) * TEX_HEIGHT);
      o.ax = mag_of(it.dx);
      o.ay = mag_of(it.dy);
      o.sgnx = it.dx[X_W-1];
      o.sgny = it.dy[X_W-1];
      o.room_x = it.dx[X_W-1] ? o.sx : COORD_W'(TEX_W_Q) - o.sx;
      o.room_y = it.dy[X_W-1] ? o.sy : COORD_W'(TEX_H_Q) - o.sy;
      o.xt = (it.dx != 0) && (DEN_W'(o.room_x) < (DEN_W'(o.ax) << 4));
      o.yt = (it.dy != 0) && (DEN_W'(o.room_y) < (DEN_W'(o.ay) << 4));
    end else if (k == K_C2) begin
      // Cross products to compare the two clip fractions.
      o.pyx = PR_W'(it.room_y) * PR_W'(it.ax);
      o.pxy = PR_W'(it.room_x) * PR_W'(it.ay);
    end else if (k == K_C3) begin
      // Pick the tightest fraction; on a tie the horizontal one stays.
      ysel = it.yt && (!it.xt || (it.pyx < it.pxy));
      if (ysel) begin
        o.tn    = it.room_y;
        o.den_a = DEN_W'(it.ay) << 4;
      end else if (it.xt) begin
        o.tn    = it.room_x;
        o.den_a = DEN_W'(it.ax) << 4;
      end else begin
        o.tn    = COORD_W'(1);
        o.den_a = DEN_W'(1);
      end
      o.den_b = o.den_a;
    end else if (k == K_C4) begin
      // Numerators of the clipped components.
      o.rem_a = DV_W'(PR_W'(it.ax) * PR_W'(it.tn));
      o.rem_b = DV_W'(PR_W'(it.ay) * PR_W'(it.tn));
      o.quo_a = '0;
      o.quo_b = '0;
    end else if (k < K_END) begin
      // Clip divider, one quotient bit per stage.
      b = CQ_BITS - 1 - (k - K_CD0);
      sh_a = DV_W'(it.den_a) << b;
      sh_b = DV_W'(it.den_b) << b;
      if (it.rem_a >= sh_a) begin
        o.rem_a = it.rem_a - sh_a;
        o.quo_a[b] = 1'b1;
      end
      if (it.rem_b >= sh_b) begin
        o.rem_b = it.rem_b - sh_b;
        o.quo_b[b] = 1'b1;
      end
    end else begin
      // End points, clamped to the texture.
      q16 = (COORD_W+2)'(it.quo_a) << 4;
      e = it.sgnx ? (COORD_W+2)'(it.sx) - q16 : (COORD_W+2)'(it.sx) + q16;
      if (e < 0) begin
        e = '0;
      end else if (e > (COORD_W+2)'(TEX_W_Q)) begin
        e = (COORD_W+2)'(TEX_W_Q);
      end
      o.ex = 14'(e[COORD_W+1:12]);
      q16 = (COORD_W+2)'(it.quo_b) << 4;
      e = it.sgny ? (COORD_W+2)'(it.sy) - q16 : (COORD_W+2)'(it.sy) + q16;
      if (e < 0) begin
        e = '0;
      end else if (e > (COORD_W+2)'(TEX_H_Q)) begin
        e = (COORD_W+2)'(TEX_H_Q);
      end
      o.ey = 13'(e[COORD_W+1:12]);
    end
    return o;
  endfunction

  // Decode an incoming item into the first stage.
  always_comb begin
    logic [18:0] cprod;
    logic [6:0]  cell_idx;
    logic [8:0]  corner;
    logic        hi_tri;
    logic [15:0] dc;
    logic [15:0] dr;
    cprod    = 19'(in_data.mesh_slot) * 19'(SLOT_RECIP);
    cell_idx = 7'(cprod >> SLOT_SHIFT);
    corner   = in_data.mesh_slot - 9'(9'(cell_idx) * 9'd6);
    hi_tri   = corner >= 9'd3;
    dc = (dens_c_r >= 16'((MAX_COLS + 1) * 256)) ? 16'(MAX_COLS * 256) : dens_c_r;
    dr = (dens_r_r >= 16'((MAX_ROWS + 1) * 256)) ? 16'(MAX_ROWS * 256) : dens_r_r;
    ent       = '0;
    ent.vld   = in_valid;
    ent.ld    = !in_data.func;
    ent.wen   = 32'(in_data.mesh_slot) < MESH_SLOTS;
    ent.row   = ROW_W'({cell_idx, hi_tri});
    ent.lane  = hi_tri ? 2'(corner - 9'd3) : 2'(corner);
    ent.wdata = {in_data.mesh_v, in_data.mesh_u};
    ent.ok    = in_data.func && enable_r && (dc >= 16'd256) && (dr >= 16'd256) &&
                ({2'b00, in_data.grid_col} < dc[15:8]) &&
                ({2'b00, in_data.grid_row} < dr[15:8]);
    ent.rem_a = DV_W'({in_data.grid_col, 8'h40, 16'h0000});
    ent.rem_b = DV_W'({in_data.grid_row, 8'h40, 16'h0000});
    ent.den_a = DEN_W'(dc - 16'd192);
    ent.den_b = DEN_W'(dr - 16'd192);
  end

  // Flow control: the pipeline halts only when a finished segment cannot move on.
  assign last_res = pipe[NST].vld && !pipe[NST].ld && pipe[NST].ok;
  assign stall    = last_res && out_valid_r && !out_ready;
  assign adv      = !stall;
  assign in_ready = adv;

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NST; k++) begin
        pipe[k].vld <= 1'b0;
      end
    end else if (adv) begin
      pipe[0] <= ent;
      for (int k = 0; k < NST; k++) begin
        pipe[k+1] <= step_fn(k, pipe[k], rd_r);
      end
    end
  end

  // The mesh row is read with the address that the triangle search is forming now.
  always_comb begin
    addr_st = step_fn(K_ADDR, pipe[K_ADDR], rd_r);
  end

  // Mesh memory: loads write and points read at the same stage, so order is kept.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_r <= mesh_mem[addr_st.row];
      if (pipe[K_ADDR].vld && pipe[K_ADDR].ld && pipe[K_ADDR].wen) begin
        mesh_mem[pipe[K_ADDR].row][pipe[K_ADDR].lane*32 +: 32] <= pipe[K_ADDR].wdata;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      if (last_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_res) begin
      out_data_r.start_x   <= 14'(pipe[NST].sx >> 12);
      out_data_r.start_y   <= 13'(pipe[NST].sy >> 12);
      out_data_r.end_x     <= pipe[NST].ex;
      out_data_r.end_y     <= pipe[NST].ey;
      out_data_r.seg_color <= color_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A stalled pipeline keeps its last stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(pipe[NST]))
    else $error("last stage changed during a stall");

  // Only grid points produce segments.
  a_res_point: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe[NST].vld && pipe[NST].ok) |-> !pipe[NST].ld)
    else $error("load item reached the output as a segment");

  // A normalized vector is at most one texel long per component.
  a_norm_len: assert property (@(posedge clk) disable iff (!rst_n)
    (pipe[K_FIN+1].vld && pipe[K_FIN+1].ok && pipe[K_FIN+1].nrm) |->
      (pipe[K_FIN+1].dx <= 4096 && pipe[K_FIN+1].dx >= -4096 &&
       pipe[K_FIN+1].dy <= 4096 && pipe[K_FIN+1].dy >= -4096))
    else $error("normalized vector out of range");

  // Reset empties the output register.
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule
`default_nettype wire

>>> dv/mvsg_segment_checker.sv
// Checker for the motion vector segment generator: predicts segments and compares them.
module mvsg_segment_checker import mvsg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          segs_pending
);

  // Shadow copies of the mesh memory and the registers.
  logic [31:0] mesh_words [MESH_SLOTS];
  logic        seg_enable;
  logic [31:0] seg_rgba;
  int          dens_cols, dens_rows;
  longint      shift_x, shift_y, len_scale;
  out_item_t   seg_fifo [$];
  int          errors;

  assign fail_count   = errors;
  assign segs_pending = seg_fifo.size();

  initial begin
    errors = 0;
    foreach (mesh_words[i]) mesh_words[i] = '0;
  end

  // Integer square root, rounding down.
  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Places a point on one axis; returns zero when the axis is disabled or past the grid.
  function automatic bit place_axis(int idx, int dens, int maxn, longint off,
                                    output longint pos);
    longint d;
    d = dens;
    pos = 0;
    if (d >= (maxn + 1) * 256) d = maxn * 256;
    if (d < 256 || idx >= (d >> 8)) return 0;
    pos = ((longint'(idx) * 256 + 64) << 16) / (d - 192) + off;
    return 1;
  endfunction

  // Shrinks the clip fraction tn/td when this edge is closer.
  function automatic void tighten_clip(longint room, longint d16, inout longint tn,
                                       inout longint td);
    if (room * td < tn * d16) begin
      tn = room;
      td = d16;
    end
  endfunction

  function automatic longint clip_end(longint s, longint d, longint tn, longint td,
                                      longint lim);
    longint e;
    e = s + (d * tn / td) * 16;
    if (e < 0) e = 0;
    if (e > lim) e = lim;
    return e >>> 12;
  endfunction

  // Computes the segment of one grid point; returns zero when no segment is made.
  function automatic bit predict_segment(in_item_t it, output out_item_t seg);
    longint px, py, ax, ay, fx, fy, uacc, vacc, dx, dy, sx, sy, tn, td, l;
    longint wt [3];
    longint unsigned len2;
    int base;
    logic [31:0] e;
    seg = '0;
    if (!seg_enable) return 0;
    if (!place_axis(it.grid_col, dens_cols, MAX_COLS, shift_x, px)) return 0;
    if (!place_axis(it.grid_row, dens_rows, MAX_ROWS, -shift_y, py)) return 0;
    if (px < EDGE_LO || px > EDGE_HI || py < EDGE_LO || py > EDGE_HI) return 0;
    ax = px * MESH_DIM;
    ay = py * MESH_DIM;
    fx = ax & 64'hFFFF;
    fy = ay & 64'hFFFF;
    base = int'(((ay >>> 16) * MESH_DIM + (ax >>> 16)) * 6);
    if (fx + fy <= 65536) begin
      wt[0] = 65536 - fx - fy; wt[1] = fx; wt[2] = fy;
    end else begin
      base = base + 3;
      wt[0] = 65536 - fy; wt[1] = fx + fy - 65536; wt[2] = 65536 - fx;
    end
    uacc = 0;
    vacc = 0;
    for (int i = 0; i < 3; i++) begin
      e = mesh_words[(base + i) % MESH_SLOTS];
      uacc += longint'($signed(e[15:0])) * wt[i];
      vacc += longint'($signed(e[31:16])) * wt[i];
    end
    dx = ((uacc - (64'sd1 << 19) - px * TEX_WIDTH * 16) * len_scale) >>> 16;
    dy = ((vacc - (64'sd1 << 19) - py * TEX_HEIGHT * 16) * len_scale) >>> 16;
    // Short vectors are stretched to one texel; a null vector points down-right.
    len2 = longint'(dx * dx) + longint'(dy * dy);
    if (len2 == 0) begin
      dx = 4096;
      dy = 4096;
    end else if (len2 < (64'd1 << 24)) begin
      l = longint'(int_sqrt(len2));
      dx = dx * 4096 / l;
      dy = dy * 4096 / l;
    end
    // Clip the segment to the texture.
    sx = px * TEX_WIDTH;
    sy = py * TEX_HEIGHT;
    tn = 1;
    td = 1;
    if (dx > 0) tighten_clip(longint'(TEX_WIDTH) * 65536 - sx, dx * 16, tn, td);
    if (dx < 0) tighten_clip(sx, -dx * 16, tn, td);
    if (dy > 0) tighten_clip(longint'(TEX_HEIGHT) * 65536 - sy, dy * 16, tn, td);
    if (dy < 0) tighten_clip(sy, -dy * 16, tn, td);
    seg.start_x   = 14'(sx >>> 12);
    seg.start_y   = 13'(sy >>> 12);
    seg.end_x     = 14'(clip_end(sx, dx, tn, td, longint'(TEX_WIDTH) * 65536));
    seg.end_y     = 13'(clip_end(sy, dy, tn, td, longint'(TEX_HEIGHT) * 65536));
    seg.seg_color = seg_rgba;
    return 1;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Watch register writes, input transfers and result transfers.
  always @(posedge clk) begin
    out_item_t seg, want;
    if (!rst_n) begin
      seg_enable = 1'b0;
      seg_rgba   = '0;
      dens_cols  = 8192;
      dens_rows  = 6144;
      shift_x    = 0;
      shift_y    = 0;
      len_scale  = 256;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:       seg_enable = cfg_wdata[0];
          REG_COLOR_RGBA:   seg_rgba   = cfg_wdata;
          REG_DENSITY_COLS: dens_cols  = cfg_wdata[15:0];
          REG_DENSITY_ROWS: dens_rows  = cfg_wdata[15:0];
          REG_OFFSET_X:     shift_x    = longint'($signed(cfg_wdata[17:0]));
          REG_OFFSET_Y:     shift_y    = longint'($signed(cfg_wdata[17:0]));
          REG_VECTOR_SCALE: len_scale  = longint'($signed(cfg_wdata[15:0]));
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (!in_data.func) begin
          if (in_data.mesh_slot < MESH_SLOTS)
            mesh_words[in_data.mesh_slot] = {in_data.mesh_v, in_data.mesh_u};
        end else if (predict_segment(in_data, seg)) begin
          seg_fifo.push_back(seg);
        end
      end
      if (out_valid && out_ready) begin
        if (seg_fifo.size() == 0) begin
          $display("%0t: segment with none expected, actual %h", $time, out_data);
          errors++;
        end else begin
          want = seg_fifo.pop_front();
          check_field("start_x", want.start_x, out_data.start_x);
          check_field("start_y", want.start_y, out_data.start_y);
          check_field("end_x", want.end_x, out_data.end_x);
          check_field("end_y", want.end_y, out_data.end_y);
          check_field("seg_color", want.seg_color, out_data.seg_color);
        end
      end
    end
  end

endmodule

>>> dv/tb_motion_vector_segment_gen.sv
// Testbench top for the motion vector segment generator: stimulus, handshakes and verdict.
module tb_motion_vector_segment_gen;
  import mvsg_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          segs_pending;
  int          in_xfers;
  int          cycle_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          items_sent;

  motion_vector_segment_gen u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  mvsg_segment_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .segs_pending(segs_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count input transfers and cycles; give up at the cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (in_valid && in_ready) in_xfers <= in_xfers + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Sends one item, with a random gap first, and waits for its transfer.
  task automatic send_item(in_item_t it);
    int seen;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    seen = in_xfers;
    in_valid = 1'b1;
    in_data  = it;
    @(negedge clk);
    while (in_xfers == seen) @(negedge clk);
    in_valid = 1'b0;
    items_sent++;
    // Idle profile follows the progress of the run.
    if (items_sent < 320) begin
      tx_idle_pct = 18; rx_idle_pct = 51;
    end else if (items_sent < 640) begin
      tx_idle_pct = 51; rx_idle_pct = 18;
    end else begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
  endtask

  task automatic load_vertex(int slot, logic [15:0] u, logic [15:0] v);
    in_item_t it;
    it = '0;
    it.func      = 1'b0;
    it.mesh_slot = 9'(slot);
    it.mesh_u    = u;
    it.mesh_v    = v;
    it.grid_col  = 6'($urandom);
    it.grid_row  = 6'($urandom);
    send_item(it);
  endtask

  task automatic send_point(int col, int row);
    in_item_t it;
    it = '0;
    it.func      = 1'b1;
    it.mesh_slot = 9'($urandom);
    it.mesh_u    = 16'($urandom);
    it.mesh_v    = 16'($urandom);
    it.grid_col  = 6'(col);
    it.grid_row  = 6'(row);
    send_item(it);
  endtask

  // Waits until every segment has come and the pipeline has drained.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (segs_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(int en, int rgba, int dc, int dr, int ox, int oy, int sc);
    logic [31:0] vals [7];
    vals = '{en, rgba, dc, dr, ox, oy, sc};
    for (int i = 0; i < 7; i++) begin
      cfg_we    = 1'b1;
      cfg_index = 3'(i);
      cfg_wdata = vals[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  // Random traffic: mostly grid points, some mesh reloads, a few ignored loads.
  task automatic random_items(int n);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 12)
        load_vertex($urandom_range(MESH_SLOTS - 1), 16'($urandom), 16'($urandom));
      else if (pick < 15)
        load_vertex($urandom_range(511, MESH_SLOTS), 16'($urandom), 16'($urandom));
      else if (pick < 55)
        send_point($urandom_range(63), $urandom_range(47));
      else
        send_point($urandom_range(31), $urandom_range(23));
    end
  endtask

  task automatic run_phase(int en, int rgba, int dc, int dr, int ox, int oy, int sc, int n);
    wait_idle();
    write_regs(en, rgba, dc, dr, ox, oy, sc);
    random_items(n);
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_xfers    = 0;
    cycle_count = 0;
    items_sent  = 0;
    tx_idle_pct = 18;
    rx_idle_pct = 51;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The whole mesh is loaded before any point reads it.
    for (int s = 0; s < MESH_SLOTS; s++)
      load_vertex(s, 16'($urandom_range(8191)), 16'($urandom_range(4095)));
    write_regs(1, $urandom, 8192, 6144, 0, 0, 256);

    // Directed: extreme vertices, ignored slots, grid corners and past-the-grid points.
    load_vertex(0, 16'h8000, 16'h7FFF);
    load_vertex(MESH_SLOTS - 1, 16'h7FFF, 16'h8000);
    load_vertex(511, 16'hFFFF, 16'hFFFF);
    load_vertex(MESH_SLOTS, 16'h0000, 16'h0000);
    send_point(0, 0);
    send_point(31, 23);
    send_point(32, 0);
    send_point(0, 24);
    send_point(63, 47);
    send_point(16, 12);
    send_point(1, 1);
    send_point(30, 22);

    // Hold the sender until all segments are out.
    wait_idle();
    random_items(70);

    run_phase(1, 32'hFFFF_FFFF, 65535, 65535, 0, 0, 32767, 70);
    run_phase(1, 0, 16640, 12544, 3000, -3000, -32768, 70);
    run_phase(1, $urandom, 8192, 6144, 131071, -131072, 1, 30);
    run_phase(1, $urandom, 8192, 6144, -131072, 131071, 0, 30);
    run_phase(1, $urandom, 255, 6144, 0, 0, 256, 30);
    run_phase(0, $urandom, 8192, 6144, 0, 0, 256, 30);
    run_phase(1, $urandom, 2000, 3000, -1000, 500, 1, 70);
    run_phase(1, $urandom, 8192, 6144, 0, 0, 0, 70);
    run_phase(1, $urandom, $urandom_range(65535), $urandom_range(65535),
              $urandom_range(4000) - 2000, $urandom_range(4000) - 2000, $urandom, 70);

    wait_idle();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
